// ----- design/segment_segment_closest_approach_unit_macros.svh -----
// Assertion macros for the segment closest-approach unit.
// Used by the top level only; expects clk and arst_n in scope.
`ifndef SEGMENT_SEGMENT_CLOSEST_APPROACH_UNIT_MACROS_SVH
`define SEGMENT_SEGMENT_CLOSEST_APPROACH_UNIT_MACROS_SVH
// same-cycle implication
`define SSCA_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// next-cycle implication
`define SSCA_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

// ----- design/ssca_pkg.sv -----
// Shared constants and types for the segment closest-approach unit.
// No dependencies.
`default_nettype none
package ssca_pkg;
	localparam int CB = 16;                // coordinate width, signed Q8.8
	localparam int NB = CB + 1;            // closest point width
	localparam int DB = 2 * CB + 4;        // squared distance width
	localparam int PB = 17;                // parameter width, Q1.16
	localparam int SB = 2 * CB + 4;        // dot product width, signed
	localparam int W  = 4 * CB + 8;        // wide signed width for products
	localparam int QBITS = PB - 1;         // quotient bits
	localparam logic [PB-1:0] ONE_Q = PB'(1) << QBITS;
	localparam int DIV_STAGES = QBITS;

	typedef logic signed [W-1:0] wide_t;
	typedef logic signed [SB-1:0] dot_t;

	typedef struct packed {
		logic [2:0][CB-1:0] o0;
		logic [2:0][CB-1:0] d0;
		logic [2:0][CB-1:0] o1;
		logic [2:0][CB-1:0] d1;
	} geo_t;

	// one quotient in flight: fixed result or remainder/divisor
	typedef struct packed {
		logic          done;
		logic [PB-1:0] q;
		logic [W-1:0]  rem;
		logic [W-1:0]  den;
	} quot_t;

	// clamped ratio setup: fixed answers, else num in [0,den) with den > 0
	function automatic quot_t ratio_setup(input wide_t num, input wide_t den);
		quot_t r;
		r.done = 1'b1;
		r.q = '0;
		r.rem = '0;
		r.den = '0;
		if (num < 0) begin
			r.q = '0;
		end else if (den < num) begin
			r.q = ONE_Q;
		end else if (den <= 0) begin
			r.q = '0;
		end else if (num == den) begin
			r.q = ONE_Q;
		end else begin
			r.done = 1'b0;
			r.rem = num;
			r.den = den;
		end
		return r;
	endfunction

	// one restoring division step
	function automatic quot_t div_step(input quot_t x);
		quot_t r;
		logic [W:0] sh;
		r = x;
		sh = {x.rem, 1'b0};
		if (!x.done) begin
			if (sh >= {1'b0, x.den}) begin
				r.rem = W'(sh - {1'b0, x.den});
				r.q = {x.q[PB-2:0], 1'b1};
			end else begin
				r.rem = W'(sh);
				r.q = {x.q[PB-2:0], 1'b0};
			end
		end
		return r;
	endfunction
endpackage
`default_nettype wire

// ----- design/ssca_if.sv -----
// Channel interfaces: segment pair input, result output, threshold write.
// Depends on ssca_pkg.
`default_nettype none
interface ssca_pair_if import ssca_pkg::*; ();
	logic valid;
	logic ready;
	logic signed [CB-1:0] first_origin_x, first_origin_y, first_origin_z;
	logic signed [CB-1:0] first_dir_x, first_dir_y, first_dir_z;
	logic signed [CB-1:0] second_origin_x, second_origin_y, second_origin_z;
	logic signed [CB-1:0] second_dir_x, second_dir_y, second_dir_z;
	modport source (output valid, first_origin_x, first_origin_y, first_origin_z,
		first_dir_x, first_dir_y, first_dir_z, second_origin_x, second_origin_y,
		second_origin_z, second_dir_x, second_dir_y, second_dir_z, input ready);
	modport sink (input valid, first_origin_x, first_origin_y, first_origin_z,
		first_dir_x, first_dir_y, first_dir_z, second_origin_x, second_origin_y,
		second_origin_z, second_dir_x, second_dir_y, second_dir_z, output ready);
endinterface

interface ssca_result_if import ssca_pkg::*; ();
	logic valid;
	logic ready;
	logic [DB-1:0] dist_squared;
	logic [PB-1:0] first_param, second_param;
	logic signed [NB-1:0] first_near_x, first_near_y, first_near_z;
	logic signed [NB-1:0] second_near_x, second_near_y, second_near_z;
	modport source (output valid, dist_squared, first_param, second_param,
		first_near_x, first_near_y, first_near_z, second_near_x, second_near_y,
		second_near_z, input ready);
	modport sink (input valid, dist_squared, first_param, second_param,
		first_near_x, first_near_y, first_near_z, second_near_x, second_near_y,
		second_near_z, output ready);
endinterface

interface ssca_cfg_if ();
	logic valid;
	logic ready;
	logic [31:0] data;
	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface
`default_nettype wire

// ----- design/segment_segment_closest_approach_unit.sv -----
// Closest approach of two 3D segments. Accepts one segment pair per cycle and
// returns one result per pair; the whole datapath stalls as one while the
// output beat is held. The pipeline holds a 16-stage restoring divider that
// forms both Q1.16 parameters, one quotient bit a stage.
// Depends on ssca_pkg, ssca_if and the assertion macro header.
`default_nettype none
`include "segment_segment_closest_approach_unit_macros.svh"
module segment_segment_closest_approach_unit import ssca_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	ssca_pair_if.sink     pair_in,
	ssca_result_if.source result_out,
	ssca_cfg_if.sink      cfg
);
	logic [31:0] thr_q;
	logic adv;

	// threshold register
	assign cfg.ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) thr_q <= '0;
		else if (cfg.valid) thr_q <= cfg.data;
	end

	// whole pipe moves when the output slot is free
	assign adv = !result_out.valid || result_out.ready;
	assign pair_in.ready = adv;

	// stage valids
	localparam int NST = 11 + DIV_STAGES;
	logic [NST-1:0] vld_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_q <= '0;
		else if (adv) vld_q <= {vld_q[NST-2:0], pair_in.valid};
	end

	// s1: capture, offset between origins
	geo_t g_s1;
	logic signed [2:0][CB:0] w_s1;
	geo_t g_in;
	always_comb begin
		g_in.o0 = {pair_in.first_origin_z, pair_in.first_origin_y, pair_in.first_origin_x};
		g_in.d0 = {pair_in.first_dir_z, pair_in.first_dir_y, pair_in.first_dir_x};
		g_in.o1 = {pair_in.second_origin_z, pair_in.second_origin_y,
			pair_in.second_origin_x};
		g_in.d1 = {pair_in.second_dir_z, pair_in.second_dir_y, pair_in.second_dir_x};
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			g_s1 <= g_in;
			for (int i = 0; i < 3; i++)
				w_s1[i] <= (CB+1)'($signed(g_in.o0[i])) - (CB+1)'($signed(g_in.o1[i]));
		end
	end

	// s2: per-axis products
	geo_t g_s2;
	logic signed [2:0][2*CB+1:0] pa_s2, pb_s2, pc_s2, pd_s2, pe_s2;
	always_ff @(posedge clk) begin
		if (adv) begin
			g_s2 <= g_s1;
			for (int i = 0; i < 3; i++) begin
				pa_s2[i] <= (2*CB+2)'($signed(g_s1.d0[i]) * $signed(g_s1.d0[i]));
				pb_s2[i] <= (2*CB+2)'($signed(g_s1.d0[i]) * $signed(g_s1.d1[i]));
				pc_s2[i] <= (2*CB+2)'($signed(g_s1.d1[i]) * $signed(g_s1.d1[i]));
				pd_s2[i] <= (2*CB+2)'($signed(g_s1.d0[i]) * $signed(w_s1[i]));
				pe_s2[i] <= (2*CB+2)'($signed(g_s1.d1[i]) * $signed(w_s1[i]));
			end
		end
	end

	// s3: dot products
	geo_t g_s3;
	dot_t a_s3, b_s3, c_s3, d_s3, e_s3;
	always_ff @(posedge clk) begin
		if (adv) begin
			g_s3 <= g_s2;
			a_s3 <= SB'($signed(pa_s2[0])) + SB'($signed(pa_s2[1])) + SB'($signed(pa_s2[2]));
			b_s3 <= SB'($signed(pb_s2[0])) + SB'($signed(pb_s2[1])) + SB'($signed(pb_s2[2]));
			c_s3 <= SB'($signed(pc_s2[0])) + SB'($signed(pc_s2[1])) + SB'($signed(pc_s2[2]));
			d_s3 <= SB'($signed(pd_s2[0])) + SB'($signed(pd_s2[1])) + SB'($signed(pd_s2[2]));
			e_s3 <= SB'($signed(pe_s2[0])) + SB'($signed(pe_s2[1])) + SB'($signed(pe_s2[2]));
		end
	end

	// s4: cross products of dot products
	geo_t g_s4;
	dot_t a_s4, b_s4, c_s4, d_s4, e_s4;
	wide_t ac_s4, bb_s4, be_s4, cd_s4, ae_s4, bd_s4;
	always_ff @(posedge clk) begin
		if (adv) begin
			g_s4 <= g_s3;
			a_s4 <= a_s3; b_s4 <= b_s3; c_s4 <= c_s3; d_s4 <= d_s3; e_s4 <= e_s3;
			ac_s4 <= W'(a_s3 * c_s3);
			bb_s4 <= W'(b_s3 * b_s3);
			be_s4 <= W'(b_s3 * e_s3);
			cd_s4 <= W'(c_s3 * d_s3);
			ae_s4 <= W'(a_s3 * e_s3);
			bd_s4 <= W'(b_s3 * d_s3);
		end
	end

	// s5: denominator and raw numerators
	geo_t g_s5;
	dot_t a_s5, b_s5, c_s5, d_s5, e_s5;
	wide_t den_s5, sn_s5, tn_s5;
	always_ff @(posedge clk) begin
		if (adv) begin
			g_s5 <= g_s4;
			a_s5 <= a_s4; b_s5 <= b_s4; c_s5 <= c_s4; d_s5 <= d_s4; e_s5 <= e_s4;
			den_s5 <= ac_s4 - bb_s4;
			sn_s5 <= be_s4 - cd_s4;
			tn_s5 <= ae_s4 - bd_s4;
		end
	end

	// s6: parallel test and clamp of the first parameter
	geo_t g_s6;
	dot_t a_s6, b_s6, d_s6;
	wide_t sn_s6, sd_s6, tn_s6, td_s6;
	always_ff @(posedge clk) begin
		if (adv) begin
			g_s6 <= g_s5;
			a_s6 <= a_s5; b_s6 <= b_s5; d_s6 <= d_s5;
			if (den_s5 <= $signed({{(W-32){1'b0}}, thr_q})) begin
				sn_s6 <= '0; sd_s6 <= W'(c_s5); tn_s6 <= W'(e_s5); td_s6 <= W'(c_s5);
			end else if (sn_s5 < 0) begin
				sn_s6 <= '0; sd_s6 <= den_s5; tn_s6 <= W'(e_s5); td_s6 <= W'(c_s5);
			end else if (den_s5 < sn_s5) begin
				sn_s6 <= den_s5; sd_s6 <= den_s5;
				tn_s6 <= W'(e_s5) + W'(b_s5); td_s6 <= W'(c_s5);
			end else begin
				sn_s6 <= sn_s5; sd_s6 <= den_s5; tn_s6 <= tn_s5; td_s6 <= den_s5;
			end
		end
	end

	// s7: clamp of the second parameter, divider setup
	geo_t  g_dv [0:DIV_STAGES];
	quot_t sq_dv [0:DIV_STAGES];
	quot_t tq_dv [0:DIV_STAGES];
	always_ff @(posedge clk) begin
		if (adv) begin
			g_dv[0] <= g_s6;
			if (tn_s6 < 0) begin
				tq_dv[0] <= ratio_setup('0, '0);
				sq_dv[0] <= ratio_setup(-W'(d_s6), W'(a_s6));
			end else if (td_s6 < tn_s6) begin
				tq_dv[0] <= ratio_setup(W'(1), '0);
				sq_dv[0] <= ratio_setup(W'(b_s6) - W'(d_s6), W'(a_s6));
			end else begin
				tq_dv[0] <= ratio_setup(tn_s6, td_s6);
				sq_dv[0] <= ratio_setup(sn_s6, sd_s6);
			end
		end
	end

	// divider: one quotient bit per stage for both parameters
	for (genvar k = 1; k <= DIV_STAGES; k++) begin : g_div
		always_ff @(posedge clk) begin
			if (adv) begin
				g_dv[k]  <= g_dv[k-1];
				sq_dv[k] <= div_step(sq_dv[k-1]);
				tq_dv[k] <= div_step(tq_dv[k-1]);
			end
		end
	end

	// n1: parameter times direction
	geo_t g_n1;
	logic [PB-1:0] s_n1, t_n1;
	logic signed [2:0][PB+CB-1:0] ps_n1, pt_n1;
	always_ff @(posedge clk) begin
		if (adv) begin
			g_n1 <= g_dv[DIV_STAGES];
			s_n1 <= sq_dv[DIV_STAGES].q;
			t_n1 <= tq_dv[DIV_STAGES].q;
			for (int i = 0; i < 3; i++) begin
				ps_n1[i] <= (PB+CB)'($signed({1'b0, sq_dv[DIV_STAGES].q})
					* $signed(g_dv[DIV_STAGES].d0[i]));
				pt_n1[i] <= (PB+CB)'($signed({1'b0, tq_dv[DIV_STAGES].q})
					* $signed(g_dv[DIV_STAGES].d1[i]));
			end
		end
	end

	// n2: closest points, offset truncated toward zero
	function automatic logic signed [NB-1:0] near_pt(input logic [CB-1:0] org,
			input logic signed [PB+CB-1:0] p);
		logic [PB+CB-1:0] mag;
		logic [NB-1:0] m;
		mag = p[PB+CB-1] ? (PB+CB)'(-p) : p;
		m = NB'(mag >> QBITS);
		return p[PB+CB-1] ? NB'($signed(org)) - $signed(m) : NB'($signed(org)) + $signed(m);
	endfunction

	logic [PB-1:0] s_n2, t_n2;
	logic signed [2:0][NB-1:0] p0_n2, p1_n2;
	always_ff @(posedge clk) begin
		if (adv) begin
			s_n2 <= s_n1; t_n2 <= t_n1;
			for (int i = 0; i < 3; i++) begin
				p0_n2[i] <= near_pt(g_n1.o0[i], ps_n1[i]);
				p1_n2[i] <= near_pt(g_n1.o1[i], pt_n1[i]);
			end
		end
	end

	// n3: squared differences
	logic [PB-1:0] s_n3, t_n3;
	logic signed [2:0][NB-1:0] p0_n3, p1_n3;
	logic [2:0][2*NB-1:0] sq_n3;
	logic signed [NB:0] df [3];
	always_comb begin
		for (int i = 0; i < 3; i++)
			df[i] = (NB+1)'($signed(p0_n2[i])) - (NB+1)'($signed(p1_n2[i]));
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			s_n3 <= s_n2; t_n3 <= t_n2; p0_n3 <= p0_n2; p1_n3 <= p1_n2;
			for (int i = 0; i < 3; i++)
				sq_n3[i] <= (2*NB)'(df[i] * df[i]);
		end
	end

	// output register: distance sum
	always_ff @(posedge clk) begin
		if (adv) begin
			result_out.dist_squared <= DB'(sq_n3[0] + sq_n3[1] + sq_n3[2]);
			result_out.first_param <= s_n3;
			result_out.second_param <= t_n3;
			result_out.first_near_x <= p0_n3[0];
			result_out.first_near_y <= p0_n3[1];
			result_out.first_near_z <= p0_n3[2];
			result_out.second_near_x <= p1_n3[0];
			result_out.second_near_y <= p1_n3[1];
			result_out.second_near_z <= p1_n3[2];
		end
	end
	assign result_out.valid = vld_q[NST-1];

	// checks
	`SSCA_ASSERT_IMPL(a_param_range, result_out.valid,
		result_out.first_param <= ONE_Q && result_out.second_param <= ONE_Q,
		"parameter above one")
	`SSCA_ASSERT_IMPL(a_stall_blocks_input, result_out.valid && !result_out.ready,
		!pair_in.ready, "input taken while output stalled")
	`SSCA_ASSERT_NEXT(a_stall_holds_pipe, result_out.valid && !result_out.ready,
		vld_q == $past(vld_q), "pipeline moved during stall")
endmodule
`default_nettype wire
